// ===== rtl/core/line_sensor_steering_duty_core_assert.svh =====
// Assertion macros shared by the steering duty checker.
`ifndef LINE_SENSOR_STEERING_DUTY_CORE_ASSERT_SVH
`define LINE_SENSOR_STEERING_DUTY_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("steering duty check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("steering duty check failed");

`endif

// ===== rtl/core/lsd_pkg.sv =====
// Shared constants, types and codes of the line sensor steering duty block.
package lsd_pkg;

    // Field and fixed-point sizes.
    localparam int SAMPLE_BITS = 8;
    localparam int FRAC_BITS   = 8;
    localparam int DUTY_LIMIT  = 10000;
    localparam int CHAN_COUNT  = 5;
    localparam int CH_W        = $clog2(CHAN_COUNT);
    localparam int DUTY_W      = 14;
    localparam int PACK_W      = SAMPLE_BITS * CHAN_COUNT;
    localparam int CFG_W       = PACK_W;
    localparam int CFG_IDX_W   = 2;
    localparam int ACTION_W    = 3;

    // Normalized value: unsigned with FRAC_BITS fraction bits.
    localparam int NORM_W = 8 + FRAC_BITS;
    localparam logic [NORM_W-1:0] NORM_MAX = '1;
    localparam int ONE_Q = 1 << FRAC_BITS;

    // Divider: dividend is (white - sample) shifted up by FRAC_BITS.
    localparam int NUM_W          = SAMPLE_BITS + FRAC_BITS;
    localparam int DIV_DIGIT_BITS = 2;
    localparam int DIV_W          = DIV_DIGIT_BITS * ((NUM_W + DIV_DIGIT_BITS - 1) / DIV_DIGIT_BITS);
    localparam int DIV_STEPS      = DIV_W / DIV_DIGIT_BITS;

    // Weighted sums, speed product and signed duty candidates.
    localparam int SUM_W  = NORM_W + 2;
    localparam int PROD_W = SUM_W + DUTY_W;
    localparam int SPD_W  = PROD_W - FRAC_BITS;
    localparam int RAW_W  = SPD_W + 2;
    localparam int SC_W   = RAW_W + 1;
    localparam int CMP_W  = SUM_W + 5;

    // Classification thresholds, compared against scaled sums.
    localparam logic [CMP_W-1:0] TH_STRAIGHT_MID = CMP_W'(4 * ONE_Q);
    localparam logic [CMP_W-1:0] TH_STRAIGHT_D   = CMP_W'(ONE_Q);
    localparam logic [CMP_W-1:0] TH_GENTLE_LO    = CMP_W'(17 * ONE_Q);
    localparam logic [CMP_W-1:0] TH_SHARP        = CMP_W'(13 * ONE_Q);
    localparam logic [CMP_W-1:0] TH_STOP_MID     = CMP_W'(3 * ONE_Q);
    localparam logic [CMP_W-1:0] TH_STOP_D       = CMP_W'(ONE_Q);

    // Register reset values.
    localparam logic [PACK_W-1:0] WHITE_RESET = 40'd276058423349;
    localparam logic [PACK_W-1:0] BLACK_RESET = 40'd94827058451;
    localparam logic [DUTY_W-1:0] BASE_RESET  = 14'd3000;
    localparam logic [DUTY_W-1:0] GAIN_RESET  = 14'd1500;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd3;

    // Action codes of a result.
    localparam logic [ACTION_W-1:0] ACT_HOLD     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_STRAIGHT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_GENTLE   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SHARP    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd4;

    // Control into and status out of the serial arithmetic units.
    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// ===== rtl/core/lsd_in_if.sv =====
// Input channel carrying the five sensor samples of one control tick.
interface lsd_in_if;
    import lsd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_far_left;
    logic [SAMPLE_BITS-1:0] sample_near_left;
    logic [SAMPLE_BITS-1:0] sample_center;
    logic [SAMPLE_BITS-1:0] sample_near_right;
    logic [SAMPLE_BITS-1:0] sample_far_right;

    modport source (
        output valid, sample_far_left, sample_near_left, sample_center,
               sample_near_right, sample_far_right,
        input  ready
    );

    modport sink (
        input  valid, sample_far_left, sample_near_left, sample_center,
               sample_near_right, sample_far_right,
        output ready
    );
endinterface

// ===== rtl/core/lsd_out_if.sv =====
// Output channel carrying the motor duties and action of one control tick.
interface lsd_out_if;
    import lsd_pkg::*;

    logic                valid;
    logic                ready;
    logic [DUTY_W-1:0]   left_duty;
    logic [DUTY_W-1:0]   right_duty;
    logic [ACTION_W-1:0] action;

    modport source (
        output valid, left_duty, right_duty, action,
        input  ready
    );

    modport sink (
        input  valid, left_duty, right_duty, action,
        output ready
    );
endinterface

// ===== rtl/core/line_sensor_steering_duty_core.sv =====
// A tick is taken only in the idle state, so one tick is processed at a time.
// Each of the five channels passes through the shared serial divider (2 quotient bits
// per cycle), the speed product is formed in the bit-serial multiplier, and the steps
// S_SUM, S_ABS, S_MIX, S_SCALE and S_FIN form the sums, duty candidates and clamped result.
// A finished result waits in an output register while the next tick is accepted.
// Reset (synchronous, active low) restores the calibration registers and clears held duties.
module line_sensor_steering_duty_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    lsd_in_if.sink                          i_sample,
    lsd_out_if.source                       o_duty,
    input  logic                            i_cfg_we,
    input  logic [lsd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lsd_pkg::CFG_W-1:0]       i_cfg_data
);
    import lsd_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_LOAD    = 10'b0000000010,
        S_DIV     = 10'b0000000100,
        S_SUM     = 10'b0000001000,
        S_ABS     = 10'b0000010000,
        S_MUL_GO  = 10'b0000100000,
        S_MUL     = 10'b0001000000,
        S_MIX     = 10'b0010000000,
        S_SCALE   = 10'b0100000000,
        S_FIN     = 10'b1000000000
    } t_state;

    // Configuration registers.
    logic [PACK_W-1:0] r_white;
    logic [PACK_W-1:0] r_black;
    logic [DUTY_W-1:0] r_base;
    logic [DUTY_W-1:0] r_gain;

    // Control state.
    t_state            r_state;
    logic [CH_W-1:0]   r_ch;
    logic              r_out_valid;
    logic [DUTY_W-1:0] r_held_l;
    logic [DUTY_W-1:0] r_held_r;

    // Datapath registers.
    logic [PACK_W-1:0]        r_samp;
    logic                     r_sat;
    logic [NORM_W-1:0]        r_norm [CHAN_COUNT];
    logic [SUM_W-1:0]         r_sl;
    logic [SUM_W-1:0]         r_sr;
    logic [SUM_W-1:0]         r_sm;
    logic [SUM_W-1:0]         r_ad;
    logic                     r_neg;
    logic                     r_straight;
    logic                     r_gentle;
    logic                     r_sharp;
    logic                     r_stop;
    logic signed [RAW_W-1:0]  r_lraw;
    logic signed [RAW_W-1:0]  r_rraw;
    logic signed [SC_W-1:0]   r_lsc;
    logic signed [SC_W-1:0]   r_rsc;
    logic [DUTY_W-1:0]        r_out_l;
    logic [DUTY_W-1:0]        r_out_r;
    logic [ACTION_W-1:0]      r_out_act;

    // Combinational signals.
    logic [SAMPLE_BITS-1:0]   w_white;
    logic [SAMPLE_BITS-1:0]   w_black;
    logic [SAMPLE_BITS-1:0]   w_clip;
    logic [SAMPLE_BITS-1:0]   w_span;
    logic [DIV_W-1:0]         w_num;
    logic [SAMPLE_BITS-1:0]   w_den;
    logic [NORM_W-1:0]        w_norm;
    t_unit_ctl                w_div_ctl;
    t_unit_sts                w_div_sts;
    logic [DIV_W-1:0]         w_quo;
    t_unit_ctl                w_mul_ctl;
    t_unit_sts                w_mul_sts;
    logic [PROD_W-1:0]        w_prod;
    logic signed [RAW_W-1:0]  w_base_s;
    logic signed [RAW_W-1:0]  w_spd_s;
    logic [CMP_W-1:0]         w_ad5;
    logic [CMP_W-1:0]         w_sm5;
    logic [DUTY_W-1:0]        w_res_l;
    logic [DUTY_W-1:0]        w_res_r;
    logic [ACTION_W-1:0]      w_res_act;
    logic                     w_out_free;

    function automatic logic [CMP_W-1:0] times5(input logic [CMP_W-1:0] x);
        return (x << 2) + x;
    endfunction

    function automatic logic signed [SC_W-1:0] times_1p5(input logic signed [RAW_W-1:0] x);
        logic signed [SC_W-1:0] xe;
        xe = SC_W'(x);
        if (x[RAW_W-1] || (x == '0)) begin
            return '0;
        end
        return xe + (xe >>> 1);
    endfunction

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [SC_W-1:0] x);
        if (x[SC_W-1]) begin
            return '0;
        end
        if (x > $signed(SC_W'(DUTY_LIMIT))) begin
            return DUTY_W'(DUTY_LIMIT);
        end
        return x[DUTY_W-1:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white <= WHITE_RESET;
            r_black <= BLACK_RESET;
            r_base  <= BASE_RESET;
            r_gain  <= GAIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WHITE: r_white <= i_cfg_data[PACK_W-1:0];
                CFG_BLACK: r_black <= i_cfg_data[PACK_W-1:0];
                CFG_BASE:  r_base  <= i_cfg_data[DUTY_W-1:0];
                CFG_GAIN:  r_gain  <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Calibration levels of the channel in work.
    always_comb begin
        w_white = '0;
        w_black = '0;
        for (int i = 0; i < CHAN_COUNT; i++) begin
            if (r_ch == CH_W'(i)) begin
                w_white = r_white[i*SAMPLE_BITS +: SAMPLE_BITS];
                w_black = r_black[i*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
    end

    // Divider operands: the sample is clamped to white before the span is taken.
    assign w_clip = (r_samp[SAMPLE_BITS-1:0] > w_white) ? w_white : r_samp[SAMPLE_BITS-1:0];
    assign w_span = w_white - w_clip;
    assign w_num  = DIV_W'({w_span, {FRAC_BITS{1'b0}}});
    assign w_den  = w_white - w_black;

    // A non-positive span between white and black, or an overflow, saturates.
    assign w_norm = (r_sat || (w_quo > DIV_W'(NORM_MAX))) ? NORM_MAX : w_quo[NORM_W-1:0];

    assign w_div_ctl.start = (r_state == S_LOAD);
    assign w_mul_ctl.start = (r_state == S_MUL_GO);

    lsd_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_sts   (w_div_sts),
        .o_quo   (w_quo)
    );

    lsd_multiplier u_multiplier (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mul_ctl),
        .i_a     (r_ad),
        .i_b     (r_gain),
        .o_sts   (w_mul_sts),
        .o_prod  (w_prod)
    );

    // Scaled sums for the classification thresholds.
    assign w_ad5 = times5(CMP_W'(r_ad));
    assign w_sm5 = times5(CMP_W'(r_sm));

    // Base duty and speed difference as signed values.
    assign w_base_s = $signed(RAW_W'(r_base));
    assign w_spd_s  = $signed(RAW_W'(w_prod[PROD_W-1:FRAC_BITS]));

    // Final selection: stop overrides, otherwise the first matching case, else hold.
    always_comb begin
        priority if (r_stop) begin
            w_res_l   = '0;
            w_res_r   = '0;
            w_res_act = ACT_STOP;
        end else if (r_straight) begin
            w_res_l   = clamp_duty($signed(SC_W'(r_base)));
            w_res_r   = clamp_duty($signed(SC_W'(r_base)));
            w_res_act = ACT_STRAIGHT;
        end else if (r_gentle) begin
            w_res_l   = clamp_duty(r_lsc);
            w_res_r   = clamp_duty(r_rsc);
            w_res_act = ACT_GENTLE;
        end else if (r_sharp) begin
            w_res_l   = clamp_duty(r_lsc);
            w_res_r   = clamp_duty(r_rsc);
            w_res_act = ACT_SHARP;
        end else begin
            w_res_l   = r_held_l;
            w_res_r   = r_held_r;
            w_res_act = ACT_HOLD;
        end
    end

    assign w_out_free = !r_out_valid || o_duty.ready;

    // Sequencer, held duties and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            r_held_l    <= '0;
            r_held_r    <= '0;
        end else begin
            // A new result takes the output register, else a transfer empties it.
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_duty.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_sample.valid) begin
                        r_ch    <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        if (r_ch == CH_W'(CHAN_COUNT - 1)) begin
                            r_state <= S_SUM;
                        end else begin
                            r_ch    <= r_ch + CH_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_SUM:    r_state <= S_ABS;
                S_ABS:    r_state <= S_MUL_GO;
                S_MUL_GO: r_state <= S_MUL;
                S_MUL: begin
                    if (w_mul_sts.done) begin
                        r_state <= S_MIX;
                    end
                end
                S_MIX:    r_state <= S_SCALE;
                S_SCALE:  r_state <= S_FIN;
                S_FIN: begin
                    if (w_out_free) begin
                        r_held_l    <= w_res_l;
                        r_held_r    <= w_res_r;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers, loaded in the step that produces them.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_sample.valid) begin
            r_samp <= {i_sample.sample_far_right, i_sample.sample_near_right,
                       i_sample.sample_center, i_sample.sample_near_left,
                       i_sample.sample_far_left};
        end
        if (r_state == S_LOAD) begin
            r_sat <= (w_white <= w_black);
        end
        if ((r_state == S_DIV) && w_div_sts.done) begin
            for (int i = 0; i < CHAN_COUNT - 1; i++) begin
                r_norm[i] <= r_norm[i+1];
            end
            r_norm[CHAN_COUNT-1] <= w_norm;
            r_samp <= {{SAMPLE_BITS{1'b0}}, r_samp[PACK_W-1:SAMPLE_BITS]};
        end
        if (r_state == S_SUM) begin
            r_sl <= SUM_W'({r_norm[0], 1'b0}) + SUM_W'(r_norm[1]);
            r_sr <= SUM_W'(r_norm[3]) + SUM_W'({r_norm[4], 1'b0});
            r_sm <= SUM_W'(r_norm[2]);
        end
        if (r_state == S_ABS) begin
            r_neg <= (r_sl < r_sr);
            r_ad  <= (r_sl < r_sr) ? (r_sr - r_sl) : (r_sl - r_sr);
        end
        if (r_state == S_MUL_GO) begin
            r_straight <= (w_sm5 > TH_STRAIGHT_MID) && (w_ad5 < TH_STRAIGHT_D);
            r_gentle   <= ((w_ad5 << 2) > TH_GENTLE_LO) && ((w_ad5 << 1) < TH_SHARP);
            r_sharp    <= ((w_ad5 << 1) > TH_SHARP);
            r_stop     <= ((w_sm5 << 2) < TH_STOP_MID) && ((CMP_W'(r_ad) << 2) < TH_STOP_D);
        end
        if (r_state == S_MIX) begin
            r_lraw <= r_neg ? (w_base_s - w_spd_s) : (w_base_s + w_spd_s);
            r_rraw <= r_neg ? (w_base_s + w_spd_s) : (w_base_s - w_spd_s);
        end
        if (r_state == S_SCALE) begin
            r_lsc <= r_sharp ? times_1p5(r_lraw) : SC_W'(r_lraw);
            r_rsc <= r_sharp ? times_1p5(r_rraw) : SC_W'(r_rraw);
        end
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_l   <= w_res_l;
            r_out_r   <= w_res_r;
            r_out_act <= w_res_act;
        end
    end

    assign i_sample.ready    = (r_state == S_IDLE);
    assign o_duty.valid      = r_out_valid;
    assign o_duty.left_duty  = r_out_l;
    assign o_duty.right_duty = r_out_r;
    assign o_duty.action     = r_out_act;
endmodule

// ===== rtl/core/lsd_divider.sv =====
// Serial restoring divider that retires one two-bit quotient digit per cycle.
module lsd_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lsd_pkg::t_unit_ctl             i_ctl,
    input  logic [lsd_pkg::DIV_W-1:0]      i_num,
    input  logic [lsd_pkg::SAMPLE_BITS-1:0] i_den,
    output lsd_pkg::t_unit_sts             o_sts,
    output logic [lsd_pkg::DIV_W-1:0]      o_quo
);
    import lsd_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic [DIV_W-1:0]          r_num;
    logic [SAMPLE_BITS-1:0]    r_den;
    logic [SAMPLE_BITS-1:0]    r_rem;
    logic [DIV_W-1:0]          r_quo;

    logic [SAMPLE_BITS-1:0]    w_rem [DIV_DIGIT_BITS+1];
    logic [SAMPLE_BITS:0]      w_trial [DIV_DIGIT_BITS];
    logic [SAMPLE_BITS:0]      w_diff [DIV_DIGIT_BITS];
    logic [DIV_DIGIT_BITS-1:0] w_digit;

    // Two chained restoring steps on the narrow partial remainder.
    always_comb begin
        w_rem[0] = r_rem;
        for (int k = 0; k < DIV_DIGIT_BITS; k++) begin
            w_trial[k] = {w_rem[k], r_num[DIV_W-1-k]};
            w_diff[k]  = w_trial[k] - {1'b0, r_den};
            if (w_trial[k] >= {1'b0, r_den}) begin
                w_digit[DIV_DIGIT_BITS-1-k] = 1'b1;
                w_rem[k+1]                  = w_diff[k][SAMPLE_BITS-1:0];
            end else begin
                w_digit[DIV_DIGIT_BITS-1-k] = 1'b0;
                w_rem[k+1]                  = w_trial[k][SAMPLE_BITS-1:0];
            end
        end
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_cnt  <= CNT_W'(DIV_STEPS);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Dividend, remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[DIV_W-DIV_DIGIT_BITS-1:0], {DIV_DIGIT_BITS{1'b0}}};
            r_rem <= w_rem[DIV_DIGIT_BITS];
            r_quo <= {r_quo[DIV_W-DIV_DIGIT_BITS-1:0], w_digit};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;
endmodule

// ===== rtl/core/lsd_multiplier.sv =====
// Serial shift-and-add multiplier that consumes one gain bit per cycle.
module lsd_multiplier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lsd_pkg::t_unit_ctl          i_ctl,
    input  logic [lsd_pkg::SUM_W-1:0]   i_a,
    input  logic [lsd_pkg::DUTY_W-1:0]  i_b,
    output lsd_pkg::t_unit_sts          o_sts,
    output logic [lsd_pkg::PROD_W-1:0]  o_prod
);
    import lsd_pkg::*;

    localparam int CNT_W = $clog2(DUTY_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [SUM_W-1:0]  r_a;
    logic [PROD_W-1:0] r_p;
    logic [SUM_W:0]    w_sum;

    // Add the multiplicand into the upper half when the current gain bit is set.
    assign w_sum = {1'b0, r_p[PROD_W-1:DUTY_W]} + (r_p[0] ? {1'b0, r_a} : '0);

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_cnt  <= CNT_W'(DUTY_W);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Partial product shifts right while the gain bits shift out below it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= i_a;
            r_p <= {{SUM_W{1'b0}}, i_b};
        end else if (r_cnt != '0) begin
            r_p <= {w_sum, r_p[DUTY_W-1:1]};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_prod     = r_p;
endmodule

// ===== rtl/core/lsd_checker.sv =====
// Port-level checks of the steering duty block and their binding to the top level.
`include "line_sensor_steering_duty_core_assert.svh"

module lsd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [lsd_pkg::DUTY_W-1:0]     i_left_duty,
    input logic [lsd_pkg::DUTY_W-1:0]     i_right_duty,
    input logic [lsd_pkg::ACTION_W-1:0]   i_action
);
    import lsd_pkg::*;

    // Delivered duties never exceed the limit.
    `LSD_ASSERT_NOW(a_duty_limit, i_out_valid, (i_left_duty <= DUTY_W'(DUTY_LIMIT)) && (i_right_duty <= DUTY_W'(DUTY_LIMIT)))

    // A stop result drives both motors to zero.
    `LSD_ASSERT_NOW(a_stop_zero, i_out_valid && (i_action == ACT_STOP), (i_left_duty == '0) && (i_right_duty == '0))

    // Driving straight gives both motors the same duty.
    `LSD_ASSERT_NOW(a_straight_even, i_out_valid && (i_action == ACT_STRAIGHT), i_left_duty == i_right_duty)

    // Ticks are processed one at a time: no transfer in the cycle after one.
    `LSD_ASSERT_NEXT(a_one_tick, i_in_valid && i_in_ready, !i_in_ready)

    // A stalled result stays in place.
    `LSD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_left_duty) && $stable(i_right_duty) && $stable(i_action))
endmodule

bind line_sensor_steering_duty_core lsd_checker u_lsd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_sample.valid),
    .i_in_ready   (i_sample.ready),
    .i_out_valid  (o_duty.valid),
    .i_out_ready  (o_duty.ready),
    .i_left_duty  (o_duty.left_duty),
    .i_right_duty (o_duty.right_duty),
    .i_action     (o_duty.action)
);
